[hw/rtl/ctma_pkg.sv]
// shared types and codes for the cell tally moment accumulator
`default_nettype none

package ctma_pkg;

  // command codes
  localparam logic [2:0] CMD_ADD_CELL    = 3'd0;
  localparam logic [2:0] CMD_TRACK       = 3'd1;
  localparam logic [2:0] CMD_END_HISTORY = 3'd2;
  localparam logic [2:0] CMD_FINALIZE    = 3'd3;
  localparam logic [2:0] CMD_RESET_MOM   = 3'd4;

  // status codes
  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_IGNORED      = 2'd1;
  localparam logic [1:0] STAT_BAD_OPERANDS = 2'd2;

  // per-cell enable and history score
  typedef struct packed {
    logic        en;
    logic [31:0] score;
  } cell_score_t;

  // per-cell moments, Q32.16 and Q32.32
  typedef struct packed {
    logic [47:0] first;
    logic [63:0] second;
  } cell_mom_t;

endpackage

`default_nettype wire

[hw/rtl/cell_tally_moment_accumulator_core.sv]
// cell tally moment accumulator: per-cell scores and moments in two memories
//
// An item is taken when start is high and busy is low; one result per item
// comes back on done for a single cycle and cannot be held off. After reset
// a clearing pass writes every cell of both memories, one cell a cycle, and
// busy stays high until it is through. Track does one read and one write of
// the score memory. End history walks every cell with a read, a square on
// the shared 32x32 multiplier and a write. Reset moments writes one cell a
// cycle. Finalize runs 17 partial products on the shared multiplier, two
// 128-step restoring divisions and a 32-step square root.
`default_nettype none

module cell_tally_moment_accumulator_core #(
  parameter int NUM_CELLS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [9:0]  cell_req,
  input  wire logic [31:0] weight,
  input  wire logic [31:0] step_length,
  input  wire logic [31:0] volume,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      mean,
  output logic [31:0]      std_error,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  localparam int IDX_W = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CELLS - 1);

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_DECODE, ST_TRK_UPD, ST_EH_RD, ST_EH_MUL, ST_EH_WR,
    ST_RM_SWEEP, ST_FIN_CHK, ST_FIN_MUL, ST_FIN_ACC, ST_DIV_M, ST_DIV_S, ST_SQRT
  } state_t;

  state_t state;

  // latched item and configuration
  logic [2:0]  cmd_q;
  logic [9:0]  cell_q;
  logic [31:0] weight_q;
  logic [31:0] step_q;
  logic [31:0] vol_q;
  logic [31:0] hist_cnt;
  logic [IDX_W-1:0] cnt;

  // memories
  ctma_pkg::cell_score_t mem_a [NUM_CELLS];
  ctma_pkg::cell_mom_t   mem_b [NUM_CELLS];
  ctma_pkg::cell_score_t rd_a;
  ctma_pkg::cell_mom_t   rd_b;
  logic                  ra_en;
  logic [IDX_W-1:0]      ra_addr;
  logic                  wa_en;
  logic                  wb_en;
  logic [IDX_W-1:0]      w_addr;
  ctma_pkg::cell_score_t wa_data;
  ctma_pkg::cell_mom_t   wb_data;

  // shared multiplier and accumulator
  logic [31:0]  mul_x;
  logic [31:0]  mul_y;
  logic [63:0]  prod;
  logic [191:0] acc;
  logic [191:0] acc_sum;
  logic [1:0]   acc_sh;
  logic         acc_first;
  logic [4:0]   fstep;

  // finalize operands and intermediate products
  logic [47:0]  f_r;
  logic [63:0]  s_r;
  logic [63:0]  nv_r;
  logic [95:0]  ns_r;
  logic [95:0]  ff_r;
  logic [63:0]  nn_r;
  logic [63:0]  vv_r;
  logic [127:0] nnvv_r;
  logic [159:0] den_r;
  logic [31:0]  mean_r;
  logic [31:0]  nm1;
  logic [95:0]  var_d;

  // divider
  logic [127:0] dvd;
  logic [159:0] rem;
  logic [6:0]   div_cnt;
  logic [159:0] dsor;
  logic [160:0] div_t;
  logic [160:0] div_diff;
  logic         div_ge;
  logic [159:0] rem_next;
  logic [127:0] dvd_next;

  // square root
  logic [63:0]  sq_x;
  logic [35:0]  sq_rem;
  logic [31:0]  sq_root;
  logic [4:0]   sq_cnt;
  logic [35:0]  sq_t;
  logic [35:0]  sq_trial;
  logic         sq_ge;
  logic [35:0]  sq_rem_next;
  logic [31:0]  sq_root_next;

  // cell decode and saturating sums
  logic [16:0]      cell_ext;
  logic             cell_ok;
  logic [IDX_W-1:0] idx;
  logic [48:0]      trk_sum;
  logic [31:0]      trk_score;
  logic [48:0]      f_sum;
  logic [47:0]      f_new;
  logic [64:0]      s_sum;
  logic [63:0]      s_new;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign cell_ext = 17'(cell_q);
  assign cell_ok  = cell_ext < 17'(NUM_CELLS);
  assign idx      = cell_ext[IDX_W-1:0];
  assign nm1      = hist_cnt - 32'd1;

  assign trk_sum   = {17'd0, rd_a.score} + {1'b0, prod[63:16]};
  assign trk_score = (|trk_sum[48:32]) ? '1 : trk_sum[31:0];
  assign f_sum     = {1'b0, rd_b.first} + {17'd0, rd_a.score};
  assign f_new     = f_sum[48] ? '1 : f_sum[47:0];
  assign s_sum     = {1'b0, rd_b.second} + {1'b0, prod};
  assign s_new     = s_sum[64] ? '1 : s_sum[63:0];

  assign var_d = (ns_r >= ff_r) ? (ns_r - ff_r) : 96'd0;

  // divider step: one quotient bit a cycle
  assign dsor     = (state == ST_DIV_M) ? {96'd0, nv_r} : den_r;
  assign div_t    = {rem, dvd[127]};
  assign div_diff = div_t - {1'b0, dsor};
  assign div_ge   = div_t >= {1'b0, dsor};
  assign rem_next = div_ge ? div_diff[159:0] : div_t[159:0];
  assign dvd_next = {dvd[126:0], div_ge};

  // square root step: two radicand bits a cycle
  assign sq_t         = {sq_rem[33:0], sq_x[63:62]};
  assign sq_trial     = {2'b00, sq_root, 2'b01};
  assign sq_ge        = sq_t >= sq_trial;
  assign sq_rem_next  = sq_ge ? (sq_t - sq_trial) : sq_t;
  assign sq_root_next = {sq_root[30:0], sq_ge};

  assign acc_sum = (acc_first ? 192'd0 : acc) + ({128'd0, prod} << {acc_sh, 5'd0});

  // partial product schedule for finalize
  always_comb begin
    mul_x     = '0;
    mul_y     = '0;
    acc_sh    = 2'd0;
    acc_first = 1'b0;
    case (fstep)
      5'd0:  begin mul_x = hist_cnt; mul_y = vol_q; acc_first = 1'b1; end
      5'd1:  begin mul_x = hist_cnt; mul_y = s_r[31:0]; acc_first = 1'b1; end
      5'd2:  begin mul_x = hist_cnt; mul_y = s_r[63:32]; acc_sh = 2'd1; end
      5'd3:  begin mul_x = f_r[31:0]; mul_y = f_r[31:0]; acc_first = 1'b1; end
      5'd4:  begin mul_x = f_r[31:0]; mul_y = {16'd0, f_r[47:32]}; acc_sh = 2'd1; end
      5'd5:  begin mul_x = {16'd0, f_r[47:32]}; mul_y = f_r[31:0]; acc_sh = 2'd1; end
      5'd6:  begin
        mul_x = {16'd0, f_r[47:32]}; mul_y = {16'd0, f_r[47:32]}; acc_sh = 2'd2;
      end
      5'd7:  begin mul_x = hist_cnt; mul_y = hist_cnt; acc_first = 1'b1; end
      5'd8:  begin mul_x = vol_q; mul_y = vol_q; acc_first = 1'b1; end
      5'd9:  begin mul_x = nn_r[31:0]; mul_y = vv_r[31:0]; acc_first = 1'b1; end
      5'd10: begin mul_x = nn_r[31:0]; mul_y = vv_r[63:32]; acc_sh = 2'd1; end
      5'd11: begin mul_x = nn_r[63:32]; mul_y = vv_r[31:0]; acc_sh = 2'd1; end
      5'd12: begin mul_x = nn_r[63:32]; mul_y = vv_r[63:32]; acc_sh = 2'd2; end
      5'd13: begin mul_x = nnvv_r[31:0]; mul_y = nm1; acc_first = 1'b1; end
      5'd14: begin mul_x = nnvv_r[63:32]; mul_y = nm1; acc_sh = 2'd1; end
      5'd15: begin mul_x = nnvv_r[95:64]; mul_y = nm1; acc_sh = 2'd2; end
      5'd16: begin mul_x = nnvv_r[127:96]; mul_y = nm1; acc_sh = 2'd3; end
      default: begin mul_x = '0; mul_y = '0; end
    endcase
    // track and end history borrow the multiplier outside finalize
    if (state == ST_DECODE) begin
      mul_x = weight_q;
      mul_y = step_q;
    end else if (state == ST_EH_MUL) begin
      mul_x = rd_a.score;
      mul_y = rd_a.score;
    end
  end

  // memory port control
  always_comb begin
    ra_en   = 1'b0;
    ra_addr = idx;
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    w_addr  = idx;
    wa_data = '0;
    wb_data = '0;
    case (state)
      ST_CLR: begin
        wa_en  = 1'b1;
        wb_en  = 1'b1;
        w_addr = cnt;
      end
      ST_DECODE: begin
        if (cell_ok) begin
          if (cmd_q == ctma_pkg::CMD_ADD_CELL) begin
            wa_en   = 1'b1;
            wb_en   = 1'b1;
            wa_data = '{en: 1'b1, score: 32'd0};
          end else if (cmd_q == ctma_pkg::CMD_TRACK || cmd_q == ctma_pkg::CMD_FINALIZE) begin
            ra_en = 1'b1;
          end
        end
      end
      ST_TRK_UPD: begin
        wa_en   = rd_a.en;
        wa_data = '{en: 1'b1, score: trk_score};
      end
      ST_EH_RD: begin
        ra_en   = 1'b1;
        ra_addr = cnt;
      end
      ST_EH_WR: begin
        wa_en   = 1'b1;
        wb_en   = rd_a.en;
        w_addr  = cnt;
        wa_data = '{en: rd_a.en, score: 32'd0};
        wb_data = '{first: f_new, second: s_new};
      end
      ST_RM_SWEEP: begin
        wb_en  = 1'b1;
        w_addr = cnt;
      end
      default: begin
        ra_en = 1'b0;
      end
    endcase
  end

  // score memory
  always_ff @(posedge clk) begin
    if (wa_en) begin
      mem_a[w_addr] <= wa_data;
    end
    if (ra_en) begin
      rd_a <= mem_a[ra_addr];
    end
  end

  // moment memory
  always_ff @(posedge clk) begin
    if (wb_en) begin
      mem_b[w_addr] <= wb_data;
    end
    if (ra_en) begin
      rd_b <= mem_b[ra_addr];
    end
  end

  // sequencer, datapath registers and result outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      cnt      <= '0;
      done     <= 1'b0;
      hist_cnt <= 32'd0;
      fstep    <= 5'd0;
    end else begin
      done <= 1'b0;
      prod <= mul_x * mul_y;
      if (cfg_valid && cfg_ready) begin
        hist_cnt <= cfg_data;
      end
      case (state)
        ST_CLR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q    <= cmd;
            cell_q   <= cell_req;
            weight_q <= weight;
            step_q   <= step_length;
            vol_q    <= volume;
            state    <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          cnt   <= '0;
          fstep <= 5'd0;
          case (cmd_q)
            ctma_pkg::CMD_ADD_CELL, ctma_pkg::CMD_TRACK, ctma_pkg::CMD_FINALIZE: begin
              if (!cell_ok) begin
                done      <= 1'b1;
                status    <= ctma_pkg::STAT_IGNORED;
                mean      <= 32'd0;
                std_error <= 32'd0;
                state     <= ST_IDLE;
              end else if (cmd_q == ctma_pkg::CMD_ADD_CELL) begin
                done      <= 1'b1;
                status    <= ctma_pkg::STAT_OK;
                mean      <= 32'd0;
                std_error <= 32'd0;
                state     <= ST_IDLE;
              end else if (cmd_q == ctma_pkg::CMD_TRACK) begin
                state <= ST_TRK_UPD;
              end else begin
                state <= ST_FIN_CHK;
              end
            end
            ctma_pkg::CMD_END_HISTORY: state <= ST_EH_RD;
            ctma_pkg::CMD_RESET_MOM:   state <= ST_RM_SWEEP;
            default: begin
              done      <= 1'b1;
              status    <= ctma_pkg::STAT_OK;
              mean      <= 32'd0;
              std_error <= 32'd0;
              state     <= ST_IDLE;
            end
          endcase
        end
        ST_TRK_UPD: begin
          done      <= 1'b1;
          status    <= rd_a.en ? ctma_pkg::STAT_OK : ctma_pkg::STAT_IGNORED;
          mean      <= 32'd0;
          std_error <= 32'd0;
          state     <= ST_IDLE;
        end
        ST_EH_RD:  state <= ST_EH_MUL;
        ST_EH_MUL: state <= ST_EH_WR;
        ST_EH_WR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            done      <= 1'b1;
            status    <= ctma_pkg::STAT_OK;
            mean      <= 32'd0;
            std_error <= 32'd0;
            state     <= ST_IDLE;
          end else begin
            state <= ST_EH_RD;
          end
        end
        ST_RM_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            done      <= 1'b1;
            status    <= ctma_pkg::STAT_OK;
            mean      <= 32'd0;
            std_error <= 32'd0;
            state     <= ST_IDLE;
          end
        end
        ST_FIN_CHK: begin
          f_r <= rd_b.first;
          s_r <= rd_b.second;
          if (!rd_a.en) begin
            done      <= 1'b1;
            status    <= ctma_pkg::STAT_IGNORED;
            mean      <= 32'd0;
            std_error <= 32'd0;
            state     <= ST_IDLE;
          end else if (hist_cnt < 32'd2 || vol_q == 32'd0) begin
            done      <= 1'b1;
            status    <= ctma_pkg::STAT_BAD_OPERANDS;
            mean      <= 32'd0;
            std_error <= 32'd0;
            state     <= ST_IDLE;
          end else begin
            state <= ST_FIN_MUL;
          end
        end
        ST_FIN_MUL: state <= ST_FIN_ACC;
        ST_FIN_ACC: begin
          acc <= acc_sum;
          case (fstep)
            5'd0:  nv_r   <= acc_sum[63:0];
            5'd2:  ns_r   <= acc_sum[95:0];
            5'd6:  ff_r   <= acc_sum[95:0];
            5'd7:  nn_r   <= acc_sum[63:0];
            5'd8:  vv_r   <= acc_sum[63:0];
            5'd12: nnvv_r <= acc_sum[127:0];
            5'd16: den_r  <= acc_sum[159:0];
            default: begin
            end
          endcase
          if (fstep == 5'd16) begin
            dvd     <= {64'd0, f_r, 16'd0};
            rem     <= '0;
            div_cnt <= 7'd0;
            state   <= ST_DIV_M;
          end else begin
            fstep <= fstep + 5'd1;
            state <= ST_FIN_MUL;
          end
        end
        ST_DIV_M: begin
          dvd     <= dvd_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'd127) begin
            mean_r  <= (|dvd_next[127:32]) ? '1 : dvd_next[31:0];
            dvd     <= {var_d, 32'd0};
            rem     <= '0;
            div_cnt <= 7'd0;
            state   <= ST_DIV_S;
          end
        end
        ST_DIV_S: begin
          dvd     <= dvd_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 7'd1;
          if (div_cnt == 7'd127) begin
            sq_x    <= dvd_next[63:0];
            sq_rem  <= '0;
            sq_root <= '0;
            sq_cnt  <= 5'd0;
            if (|dvd_next[127:64]) begin
              done      <= 1'b1;
              status    <= ctma_pkg::STAT_OK;
              mean      <= mean_r;
              std_error <= '1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          sq_x    <= {sq_x[61:0], 2'b00};
          sq_rem  <= sq_rem_next;
          sq_root <= sq_root_next;
          sq_cnt  <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd31) begin
            done      <= 1'b1;
            status    <= ctma_pkg::STAT_OK;
            mean      <= mean_r;
            std_error <= sq_root_next;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a result only ends work that was under way
  assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result without work in progress");

  // an accepted item makes the block busy
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // only a good finalize carries nonzero figures
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ctma_pkg::STAT_OK) |-> (mean == 32'd0 && std_error == 32'd0))
    else $error("nonzero figures on a failed item");

  // reads and writes of the same cell never overlap
  assert property (@(posedge clk) disable iff (rst)
    (ra_en && (wa_en || wb_en)) |-> (ra_addr != w_addr))
    else $error("read and write of one cell in the same cycle");

endmodule

`default_nettype wire
